// ===== hdl/dbgd_pkg.sv =====
// Desk button gesture decoder: shared types, codes and constants.
// No dependencies; every other file of the block imports this package.
package dbgd_pkg;

  localparam int VAL_W         = 16;
  localparam int KIND_W        = 3;
  localparam int NOW_W         = 32;
  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int IN_TDATA_W    = 104;
  localparam int NSLOT         = 4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REPORT       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RECAL        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STORE_TOP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STORE_BOTTOM = 3'd4;

  // controller motion codes
  localparam logic [1:0] MOT_DOWN = 2'd1;
  localparam logic [1:0] MOT_UP   = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_LIMIT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LIMIT   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELTA   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RECAL_HOLD  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MOVE_HOLD   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_GESTURE_GAP = 3'd5;

  // register reset values
  localparam logic [VAL_W-1:0] RST_MIN_LIMIT   = 16'h0000;
  localparam logic [VAL_W-1:0] RST_MAX_LIMIT   = 16'hFFFF;
  localparam logic [VAL_W-1:0] RST_MAX_DELTA   = 16'(1 << 8);
  localparam logic [VAL_W-1:0] RST_RECAL_HOLD  = 16'(1 << 13);
  localparam logic [VAL_W-1:0] RST_MOVE_HOLD   = 16'(1 << 9);
  localparam logic [VAL_W-1:0] RST_GESTURE_GAP = 16'(1 << 8);

  typedef struct packed {
    logic [VAL_W-1:0] min_limit;
    logic [VAL_W-1:0] max_limit;
    logic [VAL_W-1:0] max_delta;
    logic [VAL_W-1:0] recal_hold_ms;
    logic [VAL_W-1:0] move_hold_ms;
    logic [VAL_W-1:0] gesture_gap_ms;
  } cfg_t;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic             pad;
    logic [VAL_W-1:0] preset_bottom;
    logic [VAL_W-1:0] preset_top;
    logic [1:0]       motion;
    logic [VAL_W-1:0] encoder_high;
    logic [VAL_W-1:0] encoder_low;
    logic [NOW_W-1:0] now_ms;
    logic             sim_level;
    logic             btn_four;
    logic             btn_three;
    logic             btn_down;
    logic             btn_up;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
  } res_t;

  // slot order: down release, up release, report, decision
  typedef struct packed {
    logic [NSLOT-1:0] vld;
    res_t [NSLOT-1:0] slot;
  } bundle_t;

endpackage

// ===== hdl/dbgd_cfg.sv =====
// Desk button gesture decoder: configuration register file.
// Depends on dbgd_pkg.
module dbgd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dbgd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dbgd_pkg::VAL_W-1:0]          cfg_wdata,
  output dbgd_pkg::cfg_t                      cfg
);
  import dbgd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_limit      <= RST_MIN_LIMIT;
      cfg_r.max_limit      <= RST_MAX_LIMIT;
      cfg_r.max_delta      <= RST_MAX_DELTA;
      cfg_r.recal_hold_ms  <= RST_RECAL_HOLD;
      cfg_r.move_hold_ms   <= RST_MOVE_HOLD;
      cfg_r.gesture_gap_ms <= RST_GESTURE_GAP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_LIMIT:   cfg_r.min_limit      <= cfg_wdata;
        REG_MAX_LIMIT:   cfg_r.max_limit      <= cfg_wdata;
        REG_MAX_DELTA:   cfg_r.max_delta      <= cfg_wdata;
        REG_RECAL_HOLD:  cfg_r.recal_hold_ms  <= cfg_wdata;
        REG_MOVE_HOLD:   cfg_r.move_hold_ms   <= cfg_wdata;
        REG_GESTURE_GAP: cfg_r.gesture_gap_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/dbgd_core.sv =====
// Desk button gesture decoder: input register, button/press state and the
// single-pass decode that produces the result bundle of one poll.
// Depends on dbgd_pkg.
module dbgd_core #(
  parameter int TIME_BITS = dbgd_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dbgd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  dbgd_pkg::cfg_t                    cfg,
  input  logic                              load_ok,
  output logic                              load,
  output dbgd_pkg::bundle_t                 bundle
);
  import dbgd_pkg::*;

  logic                 in_v_r;
  in_item_t             in_r;
  logic                 up_held_r, down_held_r, three_held_r, four_held_r;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic signed [7:0]    press_count_r, c_dn, c_up, press_count_nxt;

  logic [63:0]          now64;
  logic [TIME_BITS-1:0] now_t, elapsed;
  logic [VAL_W:0]       lo_sum, hi_bound;
  logic [VAL_W-1:0]     step_dn, step_up, rel_target;
  logic                 dn_edge, up_edge, changed, rel_moving;
  logic                 gap_over, move_over, recal_over;

  assign load      = in_v_r & load_ok;
  assign in_tready = ~in_v_r | load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r <= in_item_t'(in_tdata);
    end
  end

  // target stepping, sums kept one bit wider
  always_comb begin
    hi_bound = {1'b0, cfg.min_limit} + {1'b0, cfg.max_delta};
    lo_sum   = {1'b0, in_r.encoder_low} + {1'b0, cfg.max_delta};
    step_dn  = ({1'b0, in_r.encoder_high} > hi_bound) ?
               in_r.encoder_high - cfg.max_delta : cfg.min_limit;
    step_up  = (lo_sum < {1'b0, cfg.max_limit}) ? lo_sum[VAL_W-1:0] : cfg.max_limit;
    rel_moving = (in_r.motion == MOT_DOWN) || (in_r.motion == MOT_UP);
    rel_target = (in_r.motion == MOT_DOWN) ? step_dn : step_up;
  end

  always_comb begin
    now64   = 64'(in_r.now_ms);
    now_t   = now64[TIME_BITS-1:0];
    dn_edge = in_r.btn_down != down_held_r;
    up_edge = in_r.btn_up != up_held_r;
    changed = dn_edge | up_edge | (in_r.btn_three != three_held_r) |
              (in_r.btn_four != four_held_r);

    bundle = '0;

    c_dn = press_count_r;
    if (dn_edge) begin
      if (in_r.btn_down) begin
        if (press_count_r > -8'sd127) c_dn = press_count_r - 8'sd1;
      end else if (rel_moving) begin
        c_dn = 8'sd0;
        bundle.vld[0]        = 1'b1;
        bundle.slot[0].kind  = KIND_TARGET;
        bundle.slot[0].value = rel_target;
      end
    end

    c_up = c_dn;
    if (up_edge) begin
      if (in_r.btn_up) begin
        if (c_dn < 8'sd127) c_up = c_dn + 8'sd1;
      end else if (rel_moving) begin
        c_up = 8'sd0;
        bundle.vld[1]        = 1'b1;
        bundle.slot[1].kind  = KIND_TARGET;
        bundle.slot[1].value = rel_target;
      end
    end

    bundle.vld[2]        = changed;
    bundle.slot[2].kind  = KIND_REPORT;
    bundle.slot[2].value = {11'd0, in_r.sim_level, in_r.btn_four, in_r.btn_three,
                            in_r.btn_down, in_r.btn_up};

    press_time_nxt = ((dn_edge & in_r.btn_down) | (up_edge & in_r.btn_up)) ?
                     now_t : press_time_r;
    elapsed    = now_t - press_time_nxt;
    recal_over = elapsed > TIME_BITS'(cfg.recal_hold_ms);
    move_over  = elapsed > TIME_BITS'(cfg.move_hold_ms);
    gap_over   = elapsed > TIME_BITS'(cfg.gesture_gap_ms);

    // one gesture decision per poll, in priority order
    press_count_nxt     = 8'sd0;
    bundle.slot[3].kind = KIND_TARGET;
    bundle.slot[3].value = '0;
    if (in_r.btn_down && in_r.btn_up && recal_over) begin
      bundle.vld[3]       = 1'b1;
      bundle.slot[3].kind = KIND_RECAL;
    end else if (in_r.btn_down && !in_r.btn_up && move_over) begin
      bundle.vld[3]        = 1'b1;
      bundle.slot[3].value = step_dn;
    end else if (in_r.btn_up && !in_r.btn_down && move_over) begin
      bundle.vld[3]        = 1'b1;
      bundle.slot[3].value = step_up;
    end else if (c_up == 8'sd1 && !in_r.btn_up && gap_over) begin
      bundle.vld[3]        = 1'b1;
      bundle.slot[3].value = in_r.preset_top;
    end else if (c_up == -8'sd1 && !in_r.btn_down && gap_over) begin
      bundle.vld[3]        = 1'b1;
      bundle.slot[3].value = in_r.preset_bottom;
    end else if (c_up == 8'sd2 && !in_r.btn_up && gap_over) begin
      bundle.vld[3]        = 1'b1;
      bundle.slot[3].kind  = KIND_STORE_TOP;
      bundle.slot[3].value = in_r.encoder_low;
    end else if (c_up == -8'sd2 && !in_r.btn_down && gap_over) begin
      bundle.vld[3]        = 1'b1;
      bundle.slot[3].kind  = KIND_STORE_BOTTOM;
      bundle.slot[3].value = in_r.encoder_high;
    end else if (!in_r.btn_down && !in_r.btn_up && gap_over) begin
      press_count_nxt = 8'sd0;   // stale sequence
    end else begin
      press_count_nxt = c_up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_held_r     <= 1'b0;
      down_held_r   <= 1'b0;
      three_held_r  <= 1'b0;
      four_held_r   <= 1'b0;
      press_time_r  <= '0;
      press_count_r <= 8'sd0;
    end else if (load) begin
      up_held_r     <= in_r.btn_up;
      down_held_r   <= in_r.btn_down;
      three_held_r  <= in_r.btn_three;
      four_held_r   <= in_r.btn_four;
      press_time_r  <= press_time_nxt;
      press_count_r <= press_count_nxt;
    end
  end

endmodule

// ===== hdl/dbgd_out.sv =====
// Desk button gesture decoder: result bundle register and the serializer
// that hands its results out one per transaction. Depends on dbgd_pkg.
module dbgd_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  dbgd_pkg::bundle_t                bundle,
  output logic                             load_ok,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dbgd_pkg::VAL_W-1:0]       out_tdata,
  output logic [dbgd_pkg::KIND_W-1:0]      out_tuser,
  output logic                             out_tlast
);
  import dbgd_pkg::*;

  logic [NSLOT-1:0] vld_r, vld_nxt, sel_mask;
  res_t [NSLOT-1:0] slot_r;
  res_t             sel;
  logic             take;

  // lowest pending slot goes first
  always_comb begin
    case (vld_r)
      4'b0000:                                      sel_mask = 4'b0000;
      4'b0001, 4'b0011, 4'b0101, 4'b0111,
      4'b1001, 4'b1011, 4'b1101, 4'b1111:           sel_mask = 4'b0001;
      4'b0010, 4'b0110, 4'b1010, 4'b1110:           sel_mask = 4'b0010;
      4'b0100, 4'b1100:                             sel_mask = 4'b0100;
      default:                                      sel_mask = 4'b1000;
    endcase
    sel = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (sel_mask[i]) sel = slot_r[i];
    end
  end

  assign out_tvalid = |vld_r;
  assign out_tlast  = (vld_r & ~sel_mask) == '0;
  assign out_tdata  = sel.value;
  assign out_tuser  = sel.kind;
  assign take       = out_tvalid & out_tready;
  assign load_ok    = ~out_tvalid | (take & out_tlast);

  always_comb begin
    vld_nxt = vld_r;
    if (load) vld_nxt = bundle.vld;
    else if (take) vld_nxt = vld_r & ~sel_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot_r <= bundle.slot;
  end

endmodule

// ===== hdl/desk_button_gesture_decoder_unit.sv =====
// Desk button gesture decoder, top level.
// Usage: one input transaction per button poll on the in_ stream; results
// leave on the out_ stream, tuser carrying the result kind, tdata the value
// and tlast marking the final result of a poll.
// Each poll yields zero to four results in order: target on down release,
// target on up release, button report, gesture decision.
// Path: a poll accepted into the input register is decoded from there
// combinationally and its results are shown from the result bundle register.
// Throughput: one poll per cycle while out_tready stays high and polls yield
// at most one result; a poll with several results holds the decoder until the
// output serializer, moving one result per transaction (up to 4 per poll), is done.
// Stall: while the receiver holds out_tready low the pending results and one
// further poll wait in their registers; in_tready drops after that.
// Reset (rst_n low, synchronous): button states, press time and press count
// clear, configuration registers return to their defaults, both streams idle.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr.
// Depends on dbgd_pkg, dbgd_cfg, dbgd_core, dbgd_out.
module desk_button_gesture_decoder_unit #(
  parameter int TIME_BITS = dbgd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // up, down, three, four, sim, now_ms[32], encoder_low[16], encoder_high[16],
  // motion[2], preset_top[16], preset_bottom[16], zero pad
  input  logic [dbgd_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dbgd_pkg::VAL_W-1:0]      out_tdata,   // value
  output logic [dbgd_pkg::KIND_W-1:0]     out_tuser,   // kind
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [dbgd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dbgd_pkg::VAL_W-1:0]      cfg_wdata
);
  import dbgd_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    load, load_ok;

  dbgd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbgd_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .load_ok   (load_ok),
    .load      (load),
    .bundle    (bundle)
  );

  dbgd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .bundle     (bundle),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/dbgd_checker.sv =====
// Desk button gesture decoder: port-level checker and its bind to the top.
// Depends on dbgd_pkg and desk_button_gesture_decoder_unit.
module dbgd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [dbgd_pkg::VAL_W-1:0]  out_tdata,
  input logic [dbgd_pkg::KIND_W-1:0] out_tuser,
  input logic                        out_tlast
);
  import dbgd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_REPORT || out_tuser == KIND_TARGET ||
                    out_tuser == KIND_RECAL || out_tuser == KIND_STORE_TOP ||
                    out_tuser == KIND_STORE_BOTTOM))
    else $error("undefined result kind");

  a_report_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPORT |-> out_tdata[VAL_W-1:5] == '0)
    else $error("report carries stray bits");

  // recalibration and store decisions close the poll
  a_decision_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RECAL || out_tuser == KIND_STORE_TOP ||
                   out_tuser == KIND_STORE_BOTTOM) |-> out_tlast)
    else $error("decision result not last of poll");

endmodule

bind desk_button_gesture_decoder_unit dbgd_checker u_dbgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
